// ----- hdl/crcu_pkg.sv -----
// shared types, codes and constants of the programmable crc unit
`default_nettype none
package crcu_pkg;

  localparam int unsigned CRC_W   = 32;
  localparam int unsigned DATA_W  = 32;
  localparam int unsigned SIZE_W  = 2;
  localparam int unsigned WSEL_W  = 2;
  localparam int unsigned INDEX_W = 2;

  // item opcodes
  localparam logic OP_LOAD = 1'b0;
  localparam logic OP_FEED = 1'b1;

  // data size codes; the unused codes act as 32 bits
  localparam logic [SIZE_W-1:0] SIZE_8  = 2'd0;
  localparam logic [SIZE_W-1:0] SIZE_16 = 2'd1;

  // polynomial width codes
  localparam logic [WSEL_W-1:0] WSEL_32 = 2'd0;
  localparam logic [WSEL_W-1:0] WSEL_16 = 2'd1;
  localparam logic [WSEL_W-1:0] WSEL_8  = 2'd2;
  localparam logic [WSEL_W-1:0] WSEL_7  = 2'd3;

  // register indexes
  localparam logic [INDEX_W-1:0] REG_POLY      = 2'd0;
  localparam logic [INDEX_W-1:0] REG_INIT      = 2'd1;
  localparam logic [INDEX_W-1:0] REG_WIDTH_SEL = 2'd2;

  localparam logic [CRC_W-1:0]  POLY_RESET = 32'h04C1_1DB7;
  localparam logic [CRC_W-1:0]  INIT_RESET = 32'hFFFF_FFFF;
  localparam logic [WSEL_W-1:0] WSEL_RESET = WSEL_32;
  localparam logic [CRC_W-1:0]  ACC_RESET  = 32'hFFFF_FFFF;

  typedef struct packed {
    logic [CRC_W-1:0]  poly;
    logic [CRC_W-1:0]  start_value;
    logic [WSEL_W-1:0] width_sel;
  } crcu_cfg_t;

  function automatic logic [CRC_W-1:0] width_mask(input logic [WSEL_W-1:0] sel);
    logic [CRC_W-1:0] m;
    case (sel)
      WSEL_32: m = 32'hFFFF_FFFF;
      WSEL_16: m = 32'h0000_FFFF;
      WSEL_8:  m = 32'h0000_00FF;
      WSEL_7:  m = 32'h0000_007F;
      default: m = 32'hFFFF_FFFF;
    endcase
    return m;
  endfunction

endpackage
`default_nettype wire

// ----- hdl/crcu_if.sv -----
// handshake channel interfaces of the programmable crc unit
`default_nettype none
interface crcu_item_if;
  import crcu_pkg::*;
  logic              valid;
  logic              ready;
  logic              op;
  logic [DATA_W-1:0] data_word;
  logic [SIZE_W-1:0] data_size;
  modport source (output valid, op, data_word, data_size, input ready);
  modport sink   (input valid, op, data_word, data_size, output ready);
endinterface

interface crcu_result_if;
  import crcu_pkg::*;
  logic             valid;
  logic             ready;
  logic [CRC_W-1:0] crc_value;
  modport source (output valid, crc_value, input ready);
  modport sink   (input valid, crc_value, output ready);
endinterface

interface crcu_cfg_if;
  import crcu_pkg::*;
  logic               valid;
  logic               ready;
  logic [INDEX_W-1:0] index;
  logic [CRC_W-1:0]   data;
  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface
`default_nettype wire

// ----- hdl/crcu_regs.sv -----
// configuration registers: polynomial, initial value, width select
`default_nettype none
module crcu_regs
  import crcu_pkg::*;
(
  input  wire logic  clk,
  input  wire logic  rst,
  crcu_cfg_if.sink   cfg,
  output crcu_cfg_t  regs
);

  crcu_cfg_t regs_q;

  assign cfg.ready = 1'b1;
  assign regs      = regs_q;

  always_ff @(posedge clk) begin
    if (rst) begin
      regs_q.poly        <= POLY_RESET;
      regs_q.start_value <= INIT_RESET;
      regs_q.width_sel   <= WSEL_RESET;
    end else if (cfg.valid) begin
      case (cfg.index)
        REG_POLY:      regs_q.poly        <= cfg.data;
        REG_INIT:      regs_q.start_value <= cfg.data;
        REG_WIDTH_SEL: regs_q.width_sel   <= cfg.data[WSEL_W-1:0];
        default: ;
      endcase
    end
  end

endmodule
`default_nettype wire

// ----- hdl/crcu_step.sv -----
// one bit of the msb-first crc shift
`default_nettype none
module crcu_step
  import crcu_pkg::*;
(
  input  wire logic [CRC_W-1:0] crc_in,
  input  wire logic             dbit,
  input  wire logic             en,
  input  wire logic [CRC_W-1:0] poly,
  input  wire logic [CRC_W-1:0] wmask,
  input  wire logic [CRC_W-1:0] top_mask,
  output      logic [CRC_W-1:0] crc_out
);

  logic             fb;
  logic [CRC_W-1:0] shifted;

  // crc_in is kept inside wmask, so the top bit is a masked or-reduce
  assign fb      = (|(crc_in & top_mask)) ^ dbit;
  assign shifted = {crc_in[CRC_W-2:0], 1'b0} & wmask;
  assign crc_out = en ? (fb ? (shifted ^ poly) : shifted) : crc_in;

endmodule
`default_nettype wire

// ----- hdl/crcu_core.sv -----
// chain of bit cells that feeds one data word through the accumulator
`default_nettype none
module crcu_core
  import crcu_pkg::*;
(
  input  wire logic [CRC_W-1:0]  acc,
  input  wire logic [DATA_W-1:0] data_word,
  input  wire logic [SIZE_W-1:0] data_size,
  input  wire logic [CRC_W-1:0]  poly,
  input  wire logic [CRC_W-1:0]  wmask,
  output      logic [CRC_W-1:0]  crc_out
);

  logic [CRC_W-1:0] chain [0:DATA_W];
  logic [CRC_W-1:0] pw;
  logic [CRC_W-1:0] top_mask;
  logic             size8;
  logic             size16;

  assign pw       = poly & wmask;
  assign top_mask = wmask ^ {1'b0, wmask[CRC_W-1:1]};
  assign size8    = (data_size == SIZE_8);
  assign size16   = (data_size == SIZE_16);
  assign chain[0] = acc & wmask;

  // cell k handles data bit DATA_W-1-k; bits above the size pass through
  for (genvar k = 0; k < DATA_W; k++) begin : g_bit
    localparam int unsigned BIT = DATA_W - 1 - k;
    logic en;
    if (BIT < 8) begin : g_lo
      assign en = 1'b1;
    end else if (BIT < 16) begin : g_mid
      assign en = !size8;
    end else begin : g_hi
      assign en = !size8 && !size16;
    end
    crcu_step u_step (
      .crc_in   (chain[k]),
      .dbit     (data_word[BIT]),
      .en       (en),
      .poly     (pw),
      .wmask    (wmask),
      .top_mask (top_mask),
      .crc_out  (chain[k+1])
    );
  end

  assign crc_out = chain[DATA_W];

endmodule
`default_nettype wire

// ----- hdl/programmable_crc_unit.sv -----
// top level of the programmable crc unit
// usage:
//   item channel: op selects load (accumulator takes the start value) or feed
//   (data_word of 8, 16 or 32 bits, right-aligned, shifted in msb first)
//   result channel: one crc_value per item, the accumulator after that item
//   masked to the selected polynomial width, upper bits zero
//   cfg channel: index 0 poly, 1 start value, 2 poly_width_sel; always ready,
//   write only while no item is in flight
// timing:
//   an item lands in an input register, the whole 8/16/32 bit update is done
//   by one chain of bit cells between that register and the result register
//   result valid once the item has moved from the input register into the result register
//   one item per cycle sustained while results are taken; the accumulator feedback through the bit
//   chain sets the clock period
// reset: accumulator all ones, poly 0x04C11DB7, start value all ones,
//   32 bit width, both stages empty
// stall: with result held, one more item is taken into the input register,
//   then ready drops until the result transfers
`default_nettype none
module programmable_crc_unit
  import crcu_pkg::*;
(
  input  wire logic    clk,
  input  wire logic    rst,
  crcu_item_if.sink    item,
  crcu_result_if.source result,
  crcu_cfg_if.sink     cfg
);

  crcu_cfg_t         regs;
  logic [CRC_W-1:0]  wmask;

  logic              s1_valid;
  logic              s1_op;
  logic [DATA_W-1:0] s1_data;
  logic [SIZE_W-1:0] s1_size;

  logic              s2_valid;
  logic [CRC_W-1:0]  crc_value;
  logic [CRC_W-1:0]  accumulator;
  logic [CRC_W-1:0]  accumulator_next;
  logic [CRC_W-1:0]  feed_crc;
  logic              advance;

  crcu_regs u_regs (
    .clk  (clk),
    .rst  (rst),
    .cfg  (cfg),
    .regs (regs)
  );

  assign wmask = width_mask(regs.width_sel);

  crcu_core u_core (
    .acc       (accumulator),
    .data_word (s1_data),
    .data_size (s1_size),
    .poly      (regs.poly),
    .wmask     (wmask),
    .crc_out   (feed_crc)
  );

  assign advance          = s1_valid && (!s2_valid || result.ready);
  assign item.ready       = !s1_valid || advance;
  assign accumulator_next = (s1_op == OP_LOAD) ? regs.start_value : feed_crc;

  assign result.valid     = s2_valid;
  assign result.crc_value = crc_value;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid    <= 1'b0;
      s2_valid    <= 1'b0;
      accumulator <= ACC_RESET;
    end else begin
      if (item.valid && item.ready) begin
        s1_valid <= 1'b1;
      end else if (advance) begin
        s1_valid <= 1'b0;
      end
      if (advance) begin
        s2_valid    <= 1'b1;
        accumulator <= accumulator_next;
      end else if (result.ready) begin
        s2_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (item.valid && item.ready) begin
      s1_op   <= item.op;
      s1_data <= item.data_word;
      s1_size <= item.data_size;
    end
    if (advance) begin
      crc_value <= accumulator_next & wmask;
    end
  end

  // a load shows the initial value, cut to width, on the next result
  a_load_result: assert property (@(posedge clk) disable iff (rst)
    advance && s1_op == OP_LOAD |=> crc_value == ($past(regs.start_value) & $past(wmask)))
    else $error("load result differs from initial value");

  // no result carries bits above the polynomial width
  a_result_width: assert property (@(posedge clk) disable iff (rst)
    advance |=> (crc_value & ~$past(wmask)) == '0)
    else $error("result has bits above polynomial width");

  // item side only backs up when the result side is stalled
  a_ready_stall: assert property (@(posedge clk) disable iff (rst)
    !item.ready |-> s1_valid && s2_valid && !result.ready)
    else $error("item channel blocked without result stall");

  // the accumulator moves only when an item completes
  a_acc_hold: assert property (@(posedge clk) disable iff (rst)
    !advance |=> $stable(accumulator))
    else $error("accumulator changed without an item");

endmodule
`default_nettype wire
